// ----- rtl/lz77_token_decompressor_top_macros.svh -----
// ----------------------------------------------------------------------------
// lz77 token decompressor assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LZ77_TOKEN_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ77_TOKEN_DECOMPRESSOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define LZ77TD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz77td: same-cycle check failed");

// next-cycle implication, off during reset
`define LZ77TD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz77td: next-cycle check failed");

`endif

// ----- rtl/lz77td_pkg.sv -----
// ----------------------------------------------------------------------------
// lz77td_pkg
// Types, codes and constants shared by the lz77 token decompressor modules.
// ----------------------------------------------------------------------------
package lz77td_pkg;

  // default configuration
  localparam int MAX_MATCH_DEF     = 64;
  localparam int HISTORY_DEPTH_DEF = 65536;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int OFFSET_W = 16;
  localparam int CMP_W    = 17;  // offset vs. produced-count compare width
  localparam int CALC_W   = 18;  // signed-style source address arithmetic

  // token decoding
  localparam int MIN_MATCH    = 3;
  localparam int LITERAL_FLAG = 7;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_OFFSET = 2'd2,
    ERR_TRUNC  = 2'd3
  } err_code_t;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LITERAL,
    PH_OFF_HI,
    PH_OFF_LO,
    PH_COPY,
    PH_SWALLOW
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;
    err_code_t         error_code;
  } out_item_t;

  typedef struct packed {
    logic copying;
    logic swallowing;
  } ctrl_status_t;

endpackage

// ----- rtl/lz77_token_decompressor_top.sv -----
// ----------------------------------------------------------------------------
// lz77_token_decompressor_top
// Byte-serial LZ77 token decoder with an on-chip history memory.
//
//   channel  valid        stall        payload     direction
//   comp     comp_valid   comp_stall   comp_item   in   compressed bytes
//   plain    plain_valid  plain_stall  plain_item  out  decoded bytes / errors
//
// A literal comes out the cycle after its data byte is taken. A match gives
// one byte per cycle for its length while the plain channel does not stall,
// paced by the single read port of the history memory; input stalls meanwhile.
// Reset clears the parser, pointers and output valid; history is unknown until written.
// A stall on the plain channel holds the output register and stalls input.
// ----------------------------------------------------------------------------
`include "lz77_token_decompressor_top_macros.svh"

module lz77_token_decompressor_top
  import lz77td_pkg::*;
#(
  parameter int MAX_MATCH     = MAX_MATCH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      comp_valid,
  output logic      comp_stall,
  input  in_item_t  comp_item,
  output logic      plain_valid,
  input  logic      plain_stall,
  output out_item_t plain_item
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int BPW = $clog2(HISTORY_DEPTH + 1);

  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  ctrl_status_t      status;

  // parser and copy sequencer
  lz77td_ctrl #(
    .MAX_MATCH    (MAX_MATCH),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .AW           (AW),
    .BPW          (BPW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (comp_valid),
    .in_stall (comp_stall),
    .in_item  (comp_item),
    .out_valid(plain_valid),
    .out_stall(plain_stall),
    .out_item (plain_item),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .status   (status)
  );

  // history memory
  lz77td_hist_mem #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_hist (
    .clk  (clk),
    .raddr(mem_raddr),
    .rdata(mem_rdata),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata)
  );

  // no compressed byte is taken while a match is being copied
  `LZ77TD_ASSERT_IMP(a_no_take_in_copy, clk, rst, status.copying, comp_stall)
  // a transaction carrying the stream's last byte never leaves the parser swallowing
  `LZ77TD_ASSERT_NXT(a_last_ends_swallow, clk, rst, comp_valid && !comp_stall && comp_item.in_last, !status.swallowing)
  // an error result is a lone zero byte closing its run
  `LZ77TD_ASSERT_IMP(a_error_shape, clk, rst, plain_valid && plain_item.error_code != ERR_OK, plain_item.out_byte == '0 && plain_item.run_last)

endmodule

// ----- rtl/lz77td_hist_mem.sv -----
// ----------------------------------------------------------------------------
// lz77td_hist_mem
// History byte store: one write port, one registered read port, with a
// write-to-read bypass for an access to the same entry in the same cycle.
// ----------------------------------------------------------------------------
module lz77td_hist_mem
  import lz77td_pkg::*;
#(
  parameter int DEPTH = HISTORY_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] q;
  logic              byp;
  logic [BYTE_W-1:0] byp_data;

  // storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  // same-entry bypass capture
  always_ff @(posedge clk) begin
    byp      <= we && (waddr == raddr);
    byp_data <= wdata;
  end

  assign rdata = byp ? byp_data : q;

endmodule

// ----- rtl/lz77td_ctrl.sv -----
// ----------------------------------------------------------------------------
// lz77td_ctrl
// Token parser, copy sequencer and output register. Drives the history memory:
// literal and copied bytes are written at the write pointer; copy sources are
// read one entry per cycle ahead of the output register while it has room.
// ----------------------------------------------------------------------------
module lz77td_ctrl
  import lz77td_pkg::*;
#(
  parameter int MAX_MATCH     = MAX_MATCH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int AW            = $clog2(HISTORY_DEPTH),
  parameter int BPW           = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  output logic [AW-1:0]     mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output ctrl_status_t      status
);

  phase_t             state;
  phase_t             state_next;
  logic [LEN_W-1:0]   match_len;
  logic [BYTE_W-1:0]  off_hi;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      rp;
  logic [BPW-1:0]     bp;
  logic               copy_last;

  logic               slot_free;
  logic               accept;
  logic [BYTE_W-1:0]  b;
  logic               last;
  logic [OFFSET_W-1:0] offset;
  logic [CALC_W-1:0]  diff;
  logic [CALC_W-1:0]  src_calc;
  logic [AW-1:0]      start_addr;
  logic [AW-1:0]      wp_inc;
  logic [AW-1:0]      rp_inc;
  logic               final_copy;

  logic               err;
  err_code_t          err_code;
  logic               load;
  out_item_t          load_item;
  logic               store;
  logic               start_copy;
  logic               copy_step;
  logic               stream_done;

  // handshake
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state == PH_COPY) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign b         = in_item.in_byte;
  assign last      = in_item.in_last;

  // copy source address: write pointer minus offset, modulo depth
  assign offset     = {off_hi, b};
  assign diff       = CALC_W'(wp) - CALC_W'(offset);
  assign src_calc   = diff[CALC_W-1] ? (diff + CALC_W'(HISTORY_DEPTH)) : diff;
  assign start_addr = src_calc[AW-1:0];

  // wrapping pointer increments
  assign wp_inc = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + AW'(1);
  assign rp_inc = (rp == AW'(HISTORY_DEPTH - 1)) ? '0 : rp + AW'(1);

  assign final_copy = (match_len == LEN_W'(1));

  // per-phase decode of results, stores and copy control
  always_comb begin
    err        = 1'b0;
    err_code   = ERR_OK;
    load       = 1'b0;
    load_item  = '0;
    store      = 1'b0;
    start_copy = 1'b0;
    copy_step  = 1'b0;
    mem_wdata  = b;
    case (state)
      PH_TOKEN: begin
        if (accept) begin
          if (b[LITERAL_FLAG]) begin
            if (last) begin
              err      = 1'b1;
              err_code = ERR_TRUNC;
            end
          end else if (b < BYTE_W'(MIN_MATCH) || b > BYTE_W'(MAX_MATCH)) begin
            err      = 1'b1;
            err_code = ERR_LENGTH;
          end else if (last) begin
            err      = 1'b1;
            err_code = ERR_TRUNC;
          end
        end
      end
      PH_LITERAL: begin
        if (accept) begin
          load      = 1'b1;
          load_item = '{out_byte: b, run_last: 1'b1, stream_end: last,
                        error_code: ERR_OK};
          store     = 1'b1;
        end
      end
      PH_OFF_HI: begin
        if (accept && last) begin
          err      = 1'b1;
          err_code = ERR_TRUNC;
        end
      end
      PH_OFF_LO: begin
        if (accept) begin
          if (offset == '0 || CMP_W'(offset) > CMP_W'(bp)) begin
            err      = 1'b1;
            err_code = ERR_OFFSET;
          end else begin
            start_copy = 1'b1;
          end
        end
      end
      PH_COPY: begin
        if (slot_free) begin
          copy_step = 1'b1;
          load      = 1'b1;
          load_item = '{out_byte: mem_rdata, run_last: final_copy,
                        stream_end: final_copy && copy_last, error_code: ERR_OK};
          store     = 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      default: begin
      end
    endcase
    if (err) begin
      load      = 1'b1;
      load_item = '{out_byte: '0, run_last: 1'b1, stream_end: last,
                    error_code: err_code};
    end
  end

  // next phase
  always_comb begin
    state_next = state;
    case (state)
      PH_TOKEN: begin
        if (accept) begin
          state_next = b[LITERAL_FLAG] ? PH_LITERAL : PH_OFF_HI;
        end
      end
      PH_LITERAL: begin
        if (accept) begin
          state_next = PH_TOKEN;
        end
      end
      PH_OFF_HI: begin
        if (accept) begin
          state_next = PH_OFF_LO;
        end
      end
      PH_OFF_LO: begin
        if (accept) begin
          state_next = PH_COPY;
        end
      end
      PH_COPY: begin
        if (copy_step && final_copy) begin
          state_next = PH_TOKEN;
        end
      end
      PH_SWALLOW: begin
        if (accept && last) begin
          state_next = PH_TOKEN;
        end
      end
      default: begin
        state_next = PH_TOKEN;
      end
    endcase
    if (err) begin
      state_next = last ? PH_TOKEN : PH_SWALLOW;
    end
  end

  // stream finishes on a last byte, or on the final copy of a last-byte match
  assign stream_done = (accept && last && !start_copy) ||
                       (copy_step && final_copy && copy_last);

  // memory ports
  assign mem_we    = store;
  assign mem_waddr = wp;
  always_comb begin
    if (start_copy) begin
      mem_raddr = start_addr;
    end else if (copy_step) begin
      mem_raddr = rp_inc;
    end else begin
      mem_raddr = rp;
    end
  end

  // phase and parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_TOKEN;
      match_len <= '0;
      off_hi    <= '0;
      copy_last <= 1'b0;
    end else begin
      state <= state_next;
      if (state == PH_TOKEN && accept && !err && !b[LITERAL_FLAG]) begin
        match_len <= b[LEN_W-1:0];
      end else if (copy_step) begin
        match_len <= match_len - LEN_W'(1);
      end
      if (state == PH_OFF_HI && accept) begin
        off_hi <= b;
      end
      if (start_copy) begin
        copy_last <= last;
      end
    end
  end

  // history pointers and produced count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      bp <= '0;
    end else begin
      if (start_copy) begin
        rp <= start_addr;
      end else if (copy_step) begin
        rp <= rp_inc;
      end
      if (store) begin
        wp <= wp_inc;
      end
      if (stream_done) begin
        bp <= '0;
      end else if (store && bp < BPW'(HISTORY_DEPTH)) begin
        bp <= bp + BPW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

  assign status.copying    = (state == PH_COPY);
  assign status.swallowing = (state == PH_SWALLOW);

endmodule

// ----- bench/tb_lz77_token_decompressor_top.sv -----
// ----------------------------------------------------------------------------
// tb_lz77_token_decompressor_top
// Self-checking bench for the byte-serial lz77 token decoder. A short table
// of directed bytes covers literals, the shortest and longest match, overlapped
// copies and every error path. Random streams follow, most of them well formed
// and the rest noise or cut short. Each accepted byte is run through a
// behavioral decoder, and the decoded bytes are compared in order as they
// leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lz77_token_decompressor_top;
  import lz77td_pkg::*;

  localparam int RAND_BYTES  = 205;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 16;
  localparam int MAX_SHOWN   = 10;
  localparam int DIR_ROWS    = 27;

  localparam out_item_t NO_RES = '0;

  // one directed stimulus row, with an optional typed-in result
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    logic       typed;
    out_item_t  res;
  } dir_row_t;

  // per-transaction tag that travels with each offered byte
  typedef struct packed {
    logic      typed;
    out_item_t res;
  } byte_tag_t;

  logic      clk;
  logic      rst;
  logic      comp_valid;
  logic      comp_stall;
  in_item_t  comp_item;
  logic      plain_valid;
  logic      plain_stall;
  out_item_t plain_item;

  // decoder state kept by the bench
  logic [7:0]  hist_mem [0:65535];
  phase_t      parse_st;
  logic [6:0]  match_len;
  logic [7:0]  off_hi;
  logic [15:0] wr_ptr;
  logic [16:0] produced;

  out_item_t decoded_q [$];
  out_item_t plain_exp_q [$];
  byte_tag_t tag_q [$];

  int  fail_cnt = 0;
  logic no_idle;
  logic hold_req;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // literal right after reset: smallest data byte
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_OK}},
    // literal with every token bit set, largest data byte
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ERR_OK}},
    // shortest match, offset one: overlapped copy
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    // longest match, offset equal to everything produced so far
    '{8'h40, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h05, 1'b0, 1'b0, NO_RES},
    // zero length, then the rest of the stream is swallowed
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_LENGTH}},
    '{8'h55, 1'b0, 1'b0, NO_RES},
    '{8'hAA, 1'b1, 1'b0, NO_RES},
    // length just over the limit on the last byte: length beats truncation
    '{8'h41, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_LENGTH}},
    // stream ends on a literal token
    '{8'h80, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_TRUNC}},
    // stream ends on a match token
    '{8'h03, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_TRUNC}},
    // stream ends on the high offset byte
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_TRUNC}},
    // offset zero, then swallow up to the last byte
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_OFFSET}},
    '{8'h12, 1'b1, 1'b0, NO_RES},
    // literal on the last byte of a stream
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h7E, 1'b1, 1'b1, '{8'h7E, 1'b1, 1'b1, ERR_OK}},
    // largest offset, far beyond a fresh stream
    '{8'h05, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_OFFSET}}
  };

  lz77_token_decompressor_top dut (
    .clk         (clk),
    .rst         (rst),
    .comp_valid  (comp_valid),
    .comp_stall  (comp_stall),
    .comp_item   (comp_item),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall),
    .plain_item  (plain_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  // clear the parser at the end of a stream
  function void close_stream();
    parse_st  = PH_TOKEN;
    match_len = '0;
    off_hi    = '0;
    produced  = '0;
  endfunction

  // append one byte to the history window
  function void keep_byte(input logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 16'd1;
    if (produced < 17'h10000) produced = produced + 17'd1;
  endfunction

  // single error result, then finish or swallow the stream
  function void flag_error(input logic lst, input err_code_t code);
    out_item_t r;
    r.out_byte   = '0;
    r.run_last   = 1'b1;
    r.stream_end = lst;
    r.error_code = code;
    decoded_q = {decoded_q, r};
    if (lst) close_stream();
    else parse_st = PH_SWALLOW;
  endfunction

  // decode one accepted stream byte into decoded_q
  function void decode_byte(input in_item_t it);
    logic [7:0]  b;
    logic        lst;
    logic [15:0] off;
    logic [15:0] src;
    out_item_t   r;
    b   = it.in_byte;
    lst = it.in_last;
    decoded_q.delete();
    case (parse_st)
      PH_TOKEN: begin
        if (b[LITERAL_FLAG]) begin
          if (lst) flag_error(lst, ERR_TRUNC);
          else parse_st = PH_LITERAL;
        end else if (b < MIN_MATCH || b > MAX_MATCH_DEF) begin
          flag_error(lst, ERR_LENGTH);
        end else if (lst) begin
          flag_error(lst, ERR_TRUNC);
        end else begin
          match_len = b[6:0];
          parse_st  = PH_OFF_HI;
        end
      end
      PH_LITERAL: begin
        keep_byte(b);
        r.out_byte   = b;
        r.run_last   = 1'b1;
        r.stream_end = lst;
        r.error_code = ERR_OK;
        decoded_q = {decoded_q, r};
        if (lst) close_stream();
        else parse_st = PH_TOKEN;
      end
      PH_OFF_HI: begin
        if (lst) begin
          flag_error(lst, ERR_TRUNC);
        end else begin
          off_hi   = b;
          parse_st = PH_OFF_LO;
        end
      end
      PH_OFF_LO: begin
        off = {off_hi, b};
        if (off == 16'd0 || {1'b0, off} > produced) begin
          flag_error(lst, ERR_OFFSET);
        end else begin
          // copy byte by byte so an overlap repeats fresh output
          for (int i = 0; i < match_len; i++) begin
            src          = wr_ptr - off;
            r.out_byte   = hist_mem[src];
            r.run_last   = (i == match_len - 1);
            r.stream_end = (i == match_len - 1) && lst;
            r.error_code = ERR_OK;
            keep_byte(hist_mem[src]);
            decoded_q = {decoded_q, r};
          end
          if (lst) close_stream();
          else parse_st = PH_TOKEN;
        end
      end
      default: begin
        if (lst) close_stream();
      end
    endcase
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one byte and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input out_item_t res);
    int        gap;
    byte_tag_t tg;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      comp_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    tg.typed = typed;
    tg.res   = res;
    tag_q = {tag_q, tg};
    comp_valid        <= 1'b1;
    comp_item.in_byte <= b;
    comp_item.in_last <= l;
    do @(posedge clk); while (comp_stall);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    comp_valid <= 1'b0;
  endtask

  // receiver: random stall runs, plus one long hold-off on request
  initial begin
    int  run;
    int  r;
    logic stall_val;
    plain_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_val = 1'b1;
        run       = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else if (no_idle) begin
        stall_val = 1'b0;
        run       = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stall_val = 1'b0;
          run       = $urandom_range(1, 8);
        end else if (r < 95) begin
          stall_val = 1'b1;
          run       = $urandom_range(1, 3);
        end else begin
          stall_val = 1'b1;
          run       = $urandom_range(20, 60);
        end
      end
      plain_stall <= stall_val;
      repeat (run - 1) @(negedge clk);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    byte_tag_t tg;
    out_item_t e;
    if (!rst) begin
      if (plain_valid && !plain_stall) begin
        if (plain_exp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("%0t: unexpected output byte=%02h run_last=%b end=%b err=%0d",
                     $realtime, plain_item.out_byte, plain_item.run_last,
                     plain_item.stream_end, plain_item.error_code);
        end else begin
          e = plain_exp_q.pop_front();
          if (plain_item.out_byte !== e.out_byte || plain_item.run_last !== e.run_last ||
              plain_item.stream_end !== e.stream_end ||
              plain_item.error_code !== e.error_code) begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN)
              $display("%0t: mismatch exp byte=%02h rl=%b end=%b err=%0d got byte=%02h rl=%b end=%b err=%0d",
                       $realtime, e.out_byte, e.run_last, e.stream_end, e.error_code,
                       plain_item.out_byte, plain_item.run_last, plain_item.stream_end,
                       plain_item.error_code);
          end
        end
      end
      if (comp_valid && !comp_stall) begin
        tg = tag_q.pop_front();
        decode_byte(comp_item);
        if (tg.typed) plain_exp_q = {plain_exp_q, tg.res};
        else plain_exp_q = {plain_exp_q, decoded_q};
      end
    end
  end

  // main sequence
  initial begin
    int          sent;
    int          sidx;
    int          ntok;
    int          n;
    int          len;
    int          gen_count;
    logic        trunc_end;
    logic        lst_tok;
    logic [15:0] off;

    rst        = 1'b1;
    comp_valid = 1'b0;
    comp_item  = '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    wr_ptr     = '0;
    close_stream();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i])
      send_byte(dir_tab[i].in_byte, dir_tab[i].in_last, dir_tab[i].typed, dir_tab[i].res);

    // random streams
    sent = 0;
    sidx = 0;
    while (sent < RAND_BYTES) begin
      no_idle = (sidx % 7 == 3);
      // long receiver hold-off while bytes keep coming
      if (sidx == 4) hold_req = 1'b1;
      // sender pause until everything has drained
      if (sidx == 9 || sidx == 20) begin
        drop_valid();
        while (plain_exp_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any bytes, random stream boundaries
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          send_byte(8'($urandom_range(0, 255)),
                    (k == n - 1) ? 1'b1 : ($urandom_range(0, 7) == 0), 1'b0, NO_RES);
          sent++;
        end
      end else begin
        // well-formed tokens, sometimes cut short at the end
        ntok      = $urandom_range(1, 10);
        trunc_end = ($urandom_range(0, 7) == 0);
        gen_count = 0;
        for (int t = 0; t < ntok; t++) begin
          lst_tok = (t == ntok - 1) && !trunc_end;
          if (gen_count == 0 || $urandom_range(0, 1) == 1) begin
            send_byte(8'(8'h80 | $urandom_range(0, 127)), 1'b0, 1'b0, NO_RES);
            send_byte(8'($urandom_range(0, 255)), lst_tok, 1'b0, NO_RES);
            gen_count++;
            sent += 2;
          end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(MIN_MATCH, MAX_MATCH_DEF)
                                              : $urandom_range(MIN_MATCH, 10);
            off = 16'(($urandom_range(0, 1) == 1)
                    ? $urandom_range(1, (gen_count < 4) ? gen_count : 4)
                    : $urandom_range(1, gen_count));
            send_byte(8'(len), 1'b0, 1'b0, NO_RES);
            send_byte(off[15:8], 1'b0, 1'b0, NO_RES);
            send_byte(off[7:0], lst_tok, 1'b0, NO_RES);
            gen_count += len;
            sent += 3;
          end
        end
        if (trunc_end) begin
          if ($urandom_range(0, 1) == 1) begin
            send_byte(8'($urandom_range(MIN_MATCH, MAX_MATCH_DEF)), 1'b1, 1'b0, NO_RES);
            sent++;
          end else begin
            send_byte(8'($urandom_range(MIN_MATCH, MAX_MATCH_DEF)), 1'b0, 1'b0, NO_RES);
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RES);
            sent += 2;
          end
        end
      end
      sidx++;
    end
    no_idle = 1'b0;
    drop_valid();

    // drain
    while (plain_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0 && plain_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
